### design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the parser checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, clocked on the rising edge, off while reset is low.
`define S2I_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("s2i: property violated");

// Implication, clocked on the rising edge, off while reset is low.
`define S2I_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("s2i: implication violated");

`endif

### design/s2i_pkg.sv
// ---------------------------------------------------------------------------
// s2i_pkg
// Types and constants shared by the string to integer parser.
// ---------------------------------------------------------------------------
package s2i_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_LEN_DEF    = 256;

  localparam int VALUE_W = 32;
  localparam int STATUS_W = 2;
  localparam int END_W    = 9;
  localparam int RADIX_W  = 6;
  localparam int PADDR_W  = 2;
  localparam int PDATA_W  = 32;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [PADDR_W-1:0] RADIX_ADDR  = 2'd0;

  localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVF = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD = 2'd2;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [STATUS_W-1:0]       status;
    logic [END_W-1:0]          end_index;
  } out_item_t;

endpackage

### design/s2i_parse_core.sv
// ---------------------------------------------------------------------------
// s2i_parse_core
// Per-character parse state and the combinational step that updates it.
// ---------------------------------------------------------------------------
module s2i_parse_core #(
  parameter int VALUE_BITS = s2i_pkg::VALUE_BITS_DEF,
  parameter int MAX_LEN    = s2i_pkg::MAX_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step_en,
  input  s2i_pkg::in_item_t               item,
  input  logic [s2i_pkg::RADIX_W-1:0]     radix,
  output s2i_pkg::out_item_t              res
);

  localparam int CI_W = $clog2(MAX_LEN + 1);
  localparam int MW   = VALUE_BITS + 7;
  localparam int VW   = s2i_pkg::VALUE_W;
  localparam int EW   = s2i_pkg::END_W;
  localparam int RW   = s2i_pkg::RADIX_W;

  localparam logic [2:0] PH_SPACE     = 3'd0;
  localparam logic [2:0] PH_PREFIX    = 3'd1;
  localparam logic [2:0] PH_ZERO_AUTO = 3'd2;
  localparam logic [2:0] PH_ZERO_HEX  = 3'd3;
  localparam logic [2:0] PH_DIGITS    = 3'd4;
  localparam logic [2:0] PH_DONE      = 3'd5;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7a;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;

  localparam logic [RW-1:0] BASE_AUTO = 6'd0;
  localparam logic [RW-1:0] BASE_MIN  = 6'd2;
  localparam logic [RW-1:0] BASE_OCT  = 6'd8;
  localparam logic [RW-1:0] BASE_DEC  = 6'd10;
  localparam logic [RW-1:0] BASE_HEX  = 6'd16;
  localparam logic [RW-1:0] BASE_MAX  = 6'd36;

  localparam logic [VALUE_BITS-1:0] POS_LIM = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] NEG_LIM = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic [2:0]            phase_r, phase_nxt;
  logic                  neg_r, neg_nxt;
  logic [RW-1:0]         base_r, base_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  any_r, any_nxt;
  logic [CI_W-1:0]       ci_r, ci_nxt;
  logic [CI_W-1:0]       stop_r, stop_nxt;

  logic [RW-1:0]         base_eff;
  logic                  is_white, is_x, is_zero;
  logic [5:0]            dig;
  logic                  dig_ok;
  logic                  do_prefix, take, zero_dig, bad_take;
  logic [MW-1:0]         mac, lim;

  logic [2:0]            phase_fin;
  logic                  any_fin;
  logic [CI_W-1:0]       stop_fin;
  logic                  bad_stat;
  logic signed [VALUE_BITS-1:0] sval;

  // Character classes and digit value.
  always_comb begin
    is_white = (item.ch == CH_SPACE) || (item.ch >= CH_TAB && item.ch <= CH_CR);
    is_x     = (item.ch == CH_LX) || (item.ch == CH_UX);
    is_zero  = (item.ch == CH_0);
    dig_ok   = 1'b1;
    dig      = '0;
    if (item.ch >= CH_0 && item.ch <= CH_9) begin
      dig = 6'(item.ch - CH_0);
    end else if (item.ch >= CH_LA && item.ch <= CH_LZ) begin
      dig = 6'(item.ch - CH_LA + 8'd10);
    end else if (item.ch >= CH_UA && item.ch <= CH_UZ) begin
      dig = 6'(item.ch - CH_UA + 8'd10);
    end else begin
      dig_ok = 1'b0;
    end
  end

  // Radix is latched on the first character of a string.
  assign base_eff = (ci_r == '0) ? radix : base_r;

  // Phase transitions and the digit step.
  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    base_nxt  = base_eff;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    stop_nxt  = stop_r;
    do_prefix = 1'b0;
    take      = 1'b0;
    zero_dig  = 1'b0;

    unique case (phase_r)
      PH_SPACE: begin
        if (!is_white) begin
          if (item.ch == CH_PLUS || item.ch == CH_MINUS) begin
            neg_nxt   = (item.ch == CH_MINUS);
            phase_nxt = PH_PREFIX;
          end else begin
            do_prefix = 1'b1;
          end
        end
      end
      PH_PREFIX: begin
        do_prefix = 1'b1;
      end
      PH_ZERO_AUTO: begin
        phase_nxt = PH_DIGITS;
        if (is_x) begin
          base_nxt = BASE_HEX;
        end else begin
          base_nxt = BASE_OCT;
          take     = 1'b1;
        end
      end
      PH_ZERO_HEX: begin
        phase_nxt = PH_DIGITS;
        if (!is_x) begin
          zero_dig = 1'b1;
          take     = 1'b1;
        end
      end
      PH_DIGITS: begin
        take = 1'b1;
      end
      default: begin
      end
    endcase

    if (do_prefix) begin
      if (base_eff == BASE_AUTO && is_zero) begin
        phase_nxt = PH_ZERO_AUTO;
      end else if (base_eff == BASE_HEX && is_zero) begin
        phase_nxt = PH_ZERO_HEX;
      end else begin
        if (base_eff == BASE_AUTO) begin
          base_nxt = BASE_DEC;
        end
        phase_nxt = PH_DIGITS;
        take      = 1'b1;
      end
    end

    // Pending hex zero counts as a digit before the next character.
    any_nxt  = any_r | zero_dig;
    bad_take = (base_nxt < BASE_MIN) || (base_nxt > BASE_MAX) || !dig_ok ||
               (dig >= base_nxt);
    mac      = MW'(acc_r) * MW'(base_nxt) + MW'(dig);
    lim      = MW'(POS_LIM) + MW'(neg_nxt);

    if (take) begin
      if (bad_take) begin
        stop_nxt  = ci_r;
        phase_nxt = PH_DONE;
      end else begin
        any_nxt = 1'b1;
        if (!ovf_r) begin
          if (mac > lim) begin
            ovf_nxt = 1'b1;
          end else begin
            acc_nxt = mac[VALUE_BITS-1:0];
          end
        end
      end
    end

    ci_nxt = (ci_r < CI_W'(MAX_LEN)) ? ci_r + 1'b1 : ci_r;
  end

  // Result for a string that ends on this character.
  always_comb begin
    phase_fin = phase_nxt;
    any_fin   = any_nxt;
    if (phase_nxt == PH_ZERO_HEX) begin
      phase_fin = PH_DIGITS;
      any_fin   = 1'b1;
    end
    stop_fin = (phase_fin != PH_DONE) ? ci_nxt : stop_nxt;
    bad_stat = (radix != BASE_AUTO) &&
               ((base_nxt < BASE_MIN) || (base_nxt > BASE_MAX));

    if (ovf_nxt) begin
      sval = neg_nxt ? NEG_LIM : POS_LIM;
    end else begin
      sval = neg_nxt ? VALUE_BITS'(-acc_nxt) : acc_nxt;
    end

    if (bad_stat) begin
      res.value     = '0;
      res.status    = s2i_pkg::ST_BAD;
      res.end_index = '0;
    end else begin
      res.value     = VW'(sval);
      res.status    = ovf_nxt ? s2i_pkg::ST_OVF : s2i_pkg::ST_OK;
      res.end_index = any_fin ? EW'(stop_fin) : '0;
    end
  end

  // Advance on each accepted item; clear after the last one.
  always_ff @(posedge clk) begin
    if (!rst_n || (step_en && item.last)) begin
      phase_r <= PH_SPACE;
      neg_r   <= 1'b0;
      base_r  <= '0;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      any_r   <= 1'b0;
      ci_r    <= '0;
      stop_r  <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      base_r  <= base_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      any_r   <= any_nxt;
      ci_r    <= ci_nxt;
      stop_r  <= stop_nxt;
    end
  end

endmodule

### design/string_to_signed_integer_parser_top.sv
// ---------------------------------------------------------------------------
// string_to_signed_integer_parser_top
// Streaming strtol-style parser: one character in per item, one result out.
// ---------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready/in_item) carries one character per item,
//   with in_item.last marking the final character of a string. Whitespace,
//   sign and radix prefix are handled as the characters stream past.
//   Result channel (out_valid/out_ready/out_item) carries one item per string:
//   signed value, status (ok, overflow saturated, bad radix) and stop index.
//   APB port holds the radix register at byte address 0 (reset value 10,
//   0 selects auto-detect); pready is tied high, so every access takes the
//   usual setup and access cycles. The radix is sampled on the first
//   character of each string.
// Timing
//   One item is accepted every cycle while in_ready is high. Each character
//   goes through a single multiply-add by the radix and a limit compare,
//   written straight into the parse state; a last character's result is
//   registered in the output register, or in the skid entry while it stalls.
// Reset and stalls
//   Reset clears the parse state and the result queue and sets radix to 10.
//   A two-entry result queue lets input keep flowing while one result waits;
//   in_ready drops for as long as both entries are full, whatever out_ready
//   does in that cycle, and rises the cycle after the output item is taken.
// ---------------------------------------------------------------------------
module string_to_signed_integer_parser_top #(
  parameter int VALUE_BITS = s2i_pkg::VALUE_BITS_DEF,
  parameter int MAX_LEN    = s2i_pkg::MAX_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  s2i_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output s2i_pkg::out_item_t            out_item,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [s2i_pkg::PADDR_W-1:0]   paddr,
  input  logic [s2i_pkg::PDATA_W-1:0]   pwdata,
  output logic [s2i_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int DW = s2i_pkg::PDATA_W;

  logic [s2i_pkg::RADIX_W-1:0] radix_r;
  logic                        cfg_wr;

  logic                        in_fire;
  logic                        push, pop;
  s2i_pkg::out_item_t          res;

  logic                        out_v_r, out_v_nxt;
  logic                        skid_v_r, skid_v_nxt;
  s2i_pkg::out_item_t          out_item_r, skid_item_r;
  logic                        load_out, load_skid, out_from_skid;

  // Configuration: single register, written at the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr == s2i_pkg::RADIX_ADDR);
  assign prdata = (paddr == s2i_pkg::RADIX_ADDR) ? DW'(radix_r) : '0;

  // Accept whenever the skid entry is free.
  assign in_ready = !skid_v_r;
  assign in_fire  = in_valid && in_ready;

  s2i_parse_core #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_LEN    (MAX_LEN)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_fire),
    .item    (in_item),
    .radix   (radix_r),
    .res     (res)
  );

  // Result queue: output register in front, skid entry behind it.
  assign push = in_fire && in_item.last;
  assign pop  = out_v_r && out_ready;

  always_comb begin
    out_v_nxt     = out_v_r;
    skid_v_nxt    = skid_v_r;
    load_out      = 1'b0;
    load_skid     = 1'b0;
    out_from_skid = 1'b0;
    if (skid_v_r) begin
      // Both full: no push possible; refill from skid on a take.
      if (pop) begin
        out_from_skid = 1'b1;
        skid_v_nxt    = 1'b0;
      end
    end else if (out_v_r) begin
      if (push && pop) begin
        load_out = 1'b1;
      end else if (push) begin
        load_skid  = 1'b1;
        skid_v_nxt = 1'b1;
      end else if (pop) begin
        out_v_nxt = 1'b0;
      end
    end else if (push) begin
      load_out  = 1'b1;
      out_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r  <= s2i_pkg::RADIX_RESET;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        radix_r <= pwdata[s2i_pkg::RADIX_W-1:0];
      end
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  // Payload holds unless loaded.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item_r <= res;
    end else if (out_from_skid) begin
      out_item_r <= skid_item_r;
    end
    if (load_skid) begin
      skid_item_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_item_r;

endmodule

### design/s2i_checker.sv
// ---------------------------------------------------------------------------
// s2i_checker
// Port-level checks for the parser, bound onto the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module s2i_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input s2i_pkg::out_item_t            out_item,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [s2i_pkg::PADDR_W-1:0]   paddr,
  input logic [s2i_pkg::PDATA_W-1:0]   pwdata,
  input logic [s2i_pkg::PDATA_W-1:0]   prdata
);

  // A stalled result holds.
  `S2I_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_item))

  // Input stalls only while a result is pending.
  `S2I_ASSERT_IMPL(a_stall_has_result, clk, rst_n, !in_ready, out_valid)

  // Status code stays within its three meanings.
  `S2I_ASSERT_IMPL(a_status_code, clk, rst_n, out_valid, out_item.status <= s2i_pkg::ST_BAD)

  // A bad radix reports zero value and zero index.
  `S2I_ASSERT_IMPL(a_bad_radix_zero, clk, rst_n, out_valid && (out_item.status == s2i_pkg::ST_BAD), (out_item.value == '0) && (out_item.end_index == '0))

  // Radix written is read back next cycle.
  `S2I_ASSERT_IMPL(a_radix_readback, clk, rst_n, (psel && penable && pwrite && (paddr == s2i_pkg::RADIX_ADDR)) ##1 (paddr == s2i_pkg::RADIX_ADDR), prdata[s2i_pkg::RADIX_W-1:0] == $past(pwdata[s2i_pkg::RADIX_W-1:0]))

endmodule

bind string_to_signed_integer_parser_top s2i_checker u_s2i_checker (.*);

### test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming string to signed integer parser.
// ---------------------------------------------------------------------------
// Characters go in one per item. Each accepted item runs through a local
// strtol-style predictor. The predictor queues the expected result whenever
// an item carries the last flag. Every accepted result is compared field by
// field against the oldest queued expectation. Directed strings cover the
// signed limits, whitespace, signs, radix prefixes and bad radixes. Random
// strings follow, under radix settings that change between strings. Both
// sides idle in random bursts, and the run ends with a stretch without any.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int CLK_HALF     = 5;
  localparam int MAX_LEN      = s2i_pkg::MAX_LEN_DEF;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_ITEMS = 100;
  localparam int TAIL_ITEMS   = 40;
  localparam int REPORT_MAX   = 10;
  localparam int RADIX_EVERY  = 8;

  // Base codes: auto-detect, the valid window, and the ones the prefixes pick
  localparam int unsigned AUTO_BASE = 0;
  localparam int unsigned MIN_BASE  = 2;
  localparam int unsigned OCT_BASE  = 8;
  localparam int unsigned DEC_BASE  = 10;
  localparam int unsigned HEX_BASE  = 16;
  localparam int unsigned MAX_BASE  = 36;
  localparam int unsigned NOT_DIGIT = 99;

  localparam longint unsigned MAG_CEILING = (64'd1 << (s2i_pkg::VALUE_W - 1)) - 64'd1;
  localparam logic [s2i_pkg::VALUE_W-1:0] POS_SAT = 32'h7fff_ffff;
  localparam logic [s2i_pkg::VALUE_W-1:0] NEG_SAT = 32'h8000_0000;

  localparam byte unsigned CH_NUL   = 8'd0;
  localparam byte unsigned CH_TAB   = 8'd9;
  localparam byte unsigned CH_CR    = 8'd13;
  localparam byte unsigned CH_SPACE = " ";
  localparam byte unsigned CH_PLUS  = "+";
  localparam byte unsigned CH_MINUS = "-";
  localparam byte unsigned CH_ZERO  = "0";
  localparam byte unsigned CH_ONE   = "1";
  localparam byte unsigned CH_NINE  = "9";
  localparam byte unsigned CH_A_LO  = "a";
  localparam byte unsigned CH_Z_LO  = "z";
  localparam byte unsigned CH_A_UP  = "A";
  localparam byte unsigned CH_Z_UP  = "Z";
  localparam byte unsigned CH_X_LO  = "x";
  localparam byte unsigned CH_X_UP  = "X";

  localparam logic [2:0] SCAN_BLANK     = 3'd0;  // skipping leading whitespace
  localparam logic [2:0] SCAN_SIGNED    = 3'd1;  // sign taken, next character leads
  localparam logic [2:0] SCAN_AUTO_ZERO = 3'd2;  // auto-detect saw a leading zero
  localparam logic [2:0] SCAN_HEX_ZERO  = 3'd3;  // radix 16 saw a leading zero
  localparam logic [2:0] SCAN_DIGITS    = 3'd4;  // accumulating digits
  localparam logic [2:0] SCAN_STOPPED   = 3'd5;  // hit an invalid character

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  s2i_pkg::in_item_t in_item;
  logic out_valid;
  logic out_ready;
  s2i_pkg::out_item_t out_item;
  logic psel;
  logic penable;
  logic pwrite;
  logic [s2i_pkg::PADDR_W-1:0] paddr;
  logic [s2i_pkg::PDATA_W-1:0] pwdata;
  logic [s2i_pkg::PDATA_W-1:0] prdata;
  logic pready;

  // Predictor state: a private copy of the radix register and the parse state
  logic [s2i_pkg::RADIX_W-1:0] radix_reg;
  logic [2:0] phase;
  bit negative;
  bit overflowed;
  bit saw_digit;
  int unsigned base;
  int unsigned char_idx;
  int unsigned stop_idx;
  longint unsigned magnitude;
  s2i_pkg::out_item_t pending_results[$];

  // Bookkeeping
  bit idle_on;
  int unsigned stall_left;
  int unsigned cycle_count;
  int unsigned items_sent;
  int unsigned strings_sent;
  int unsigned results_checked;
  int unsigned radix_writes;
  int unsigned mismatches;
  s2i_pkg::out_item_t oldest_result;
  string bad_fields;

  string_to_signed_integer_parser_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Hard stop if the run hangs anywhere
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------
  function automatic bit is_blank(byte unsigned c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic int unsigned char_to_digit(byte unsigned c);
    if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
    if (c >= CH_A_LO && c <= CH_Z_LO) return c - CH_A_LO + DEC_BASE;
    if (c >= CH_A_UP && c <= CH_Z_UP) return c - CH_A_UP + DEC_BASE;
    return NOT_DIGIT;
  endfunction

  function automatic bit base_invalid(int unsigned b);
    return b < MIN_BASE || b > MAX_BASE;
  endfunction

  function void clear_scan();
    phase      = SCAN_BLANK;
    negative   = 1'b0;
    overflowed = 1'b0;
    saw_digit  = 1'b0;
    base       = 0;
    char_idx   = 0;
    stop_idx   = 0;
    magnitude  = 0;
  endfunction

  // Fold one digit into the magnitude, or stop on anything outside the base.
  // Once saturated, digits are still consumed but the magnitude is frozen.
  function void take_digit(byte unsigned c);
    int unsigned d;
    longint unsigned lim;
    d = char_to_digit(c);
    if (base_invalid(base) || d >= base) begin
      stop_idx = char_idx;
      phase    = SCAN_STOPPED;
      return;
    end
    saw_digit = 1'b1;
    if (overflowed) return;
    // negative side reaches one further than the positive side
    lim = MAG_CEILING + (negative ? 64'd1 : 64'd0);
    if (magnitude > (lim - d) / base)
      overflowed = 1'b1;
    else
      magnitude = magnitude * base + d;
  endfunction

  // Advance the parse by one accepted character; queue a result on the last
  function void parse_char(byte unsigned c, bit last);
    bit lead;
    s2i_pkg::out_item_t res;
    lead = 1'b0;
    // latch the radix on the first character of each string
    if (char_idx == 0) base = radix_reg;
    case (phase)
      SCAN_BLANK: begin
        if (!is_blank(c)) begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            negative = (c == CH_MINUS);
            phase    = SCAN_SIGNED;
          end else begin
            lead = 1'b1;
          end
        end
      end
      SCAN_SIGNED: lead = 1'b1;
      SCAN_AUTO_ZERO: begin
        phase = SCAN_DIGITS;
        if (c == CH_X_LO || c == CH_X_UP) begin
          base = HEX_BASE;
        end else begin
          // the leading zero itself is not counted as a digit
          base = OCT_BASE;
          take_digit(c);
        end
      end
      SCAN_HEX_ZERO: begin
        phase = SCAN_DIGITS;
        if (c != CH_X_LO && c != CH_X_UP) begin
          take_digit(CH_ZERO);
          take_digit(c);
        end
      end
      SCAN_DIGITS: take_digit(c);
      default: ;
    endcase

    if (lead) begin
      if (base == AUTO_BASE && c == CH_ZERO) begin
        phase = SCAN_AUTO_ZERO;
      end else if (base == HEX_BASE && c == CH_ZERO) begin
        phase = SCAN_HEX_ZERO;
      end else begin
        if (base == AUTO_BASE) base = DEC_BASE;
        phase = SCAN_DIGITS;
        take_digit(c);
      end
    end

    if (!last) begin
      if (char_idx < MAX_LEN) char_idx++;
      return;
    end

    // a zero still pending under radix 16 counts as a digit at the end
    if (phase == SCAN_HEX_ZERO) begin
      phase = SCAN_DIGITS;
      take_digit(CH_ZERO);
    end
    if (phase != SCAN_STOPPED) stop_idx = (char_idx < MAX_LEN) ? char_idx + 1 : MAX_LEN;

    if (radix_reg != AUTO_BASE && base_invalid(base)) begin
      res.value     = '0;
      res.status    = s2i_pkg::ST_BAD;
      res.end_index = '0;
    end else begin
      if (overflowed) begin
        res.value  = negative ? NEG_SAT : POS_SAT;
        res.status = s2i_pkg::ST_OVF;
      end else begin
        res.value  = negative ? -magnitude[s2i_pkg::VALUE_W-1:0]
                              : magnitude[s2i_pkg::VALUE_W-1:0];
        res.status = s2i_pkg::ST_OK;
      end
      res.end_index = saw_digit ? stop_idx[s2i_pkg::END_W-1:0] : '0;
    end
    pending_results.push_back(res);
    clear_scan();
  endfunction

  // ------------------------------------------------------------------------
  // Result side: random back-pressure and the comparison
  // ------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        // start a stall burst; its remaining length is drawn at random
        stall_left = $urandom_range(0, 9);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic note_failure(string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("mismatch %0d at %0t: %s", mismatches, $time, msg);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result value=%0d status=%0d end=%0d",
                               out_item.value, out_item.status, out_item.end_index));
      end else begin
        oldest_result = pending_results.pop_front();
        results_checked++;
        bad_fields = "";
        if (out_item.value !== oldest_result.value) bad_fields = {bad_fields, " value"};
        if (out_item.status !== oldest_result.status) bad_fields = {bad_fields, " status"};
        if (out_item.end_index !== oldest_result.end_index)
          bad_fields = {bad_fields, " end_index"};
        if (bad_fields != "")
          note_failure($sformatf("result %0d,%s: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 results_checked, bad_fields, oldest_result.value,
                                 oldest_result.status, oldest_result.end_index,
                                 out_item.value, out_item.status, out_item.end_index));
      end
    end
  end

  // ------------------------------------------------------------------------
  // Drivers. Every task starts on a falling edge, so that each input gets
  // at most one update per time step.
  // ------------------------------------------------------------------------

  // Present one character, hold it until accepted, then predict.
  // Valid is left high: the next call replaces the item or lowers it.
  task automatic send_char(byte unsigned c, bit last);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{ch: c, last: last};
    do @(posedge clk); while (!in_ready);
    items_sent++;
    parse_char(c, last);
  endtask

  task automatic send_bytes(input byte unsigned text[$]);
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
    strings_sent++;
  endtask

  task automatic send_text(string s);
    byte unsigned text[$];
    foreach (s[i]) text.push_back(s[i]);
    send_bytes(text);
  endtask

  // Drop valid and let every expected result drain, then pause with no traffic
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(logic [s2i_pkg::PADDR_W-1:0] addr,
                           logic [s2i_pkg::PDATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(logic [s2i_pkg::PADDR_W-1:0] addr,
                          output logic [s2i_pkg::PDATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Change the radix between strings only, then read it back
  task automatic set_radix(logic [s2i_pkg::RADIX_W-1:0] r);
    logic [s2i_pkg::PDATA_W-1:0] word;
    logic [s2i_pkg::PDATA_W-1:0] readback;
    wait_idle();
    // junk in the unused upper bits half of the time
    word = $urandom();
    if ($urandom_range(0, 1) == 0) word = '0;
    word[s2i_pkg::RADIX_W-1:0] = r;
    apb_write(s2i_pkg::RADIX_ADDR, word);
    radix_reg = r;
    radix_writes++;
    apb_read(s2i_pkg::RADIX_ADDR, readback);
    if (readback[s2i_pkg::RADIX_W-1:0] !== r)
      note_failure($sformatf("radix readback %0d, wrote %0d",
                             readback[s2i_pkg::RADIX_W-1:0], r));
  endtask

  // ------------------------------------------------------------------------
  // Random string construction
  // ------------------------------------------------------------------------
  function automatic byte unsigned digit_char(int unsigned d);
    if (d < DEC_BASE) return 8'(CH_ZERO + d);
    return 8'(($urandom_range(0, 1) ? CH_A_LO : CH_A_UP) + d - DEC_BASE);
  endfunction

  function automatic logic [s2i_pkg::RADIX_W-1:0] pick_radix();
    case ($urandom_range(0, 7))
      0: return s2i_pkg::RADIX_W'(AUTO_BASE);
      1: return s2i_pkg::RADIX_W'(MIN_BASE);
      2: return s2i_pkg::RADIX_W'(OCT_BASE);
      3: return s2i_pkg::RADIX_W'(HEX_BASE);
      4: return s2i_pkg::RADIX_W'(MAX_BASE);
      5: return s2i_pkg::RADIX_W'($urandom_range(0, 63));
      default: return s2i_pkg::RADIX_W'(DEC_BASE);
    endcase
  endfunction

  // Mostly well-formed numbers with random content: blanks, sign, prefix,
  // digits valid in the base (sometimes enough to overflow), trailing junk.
  // One in ten is plain noise over the full byte range.
  function automatic void make_number(ref byte unsigned text[$], input int unsigned r);
    int unsigned eb;
    int unsigned n;
    int unsigned full;
    int unsigned k;
    longint unsigned span;
    text.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) begin
        k = $urandom_range(CH_TAB - 1, CH_CR);
        text.push_back(k < CH_TAB ? CH_SPACE : 8'(k));
      end
    case ($urandom_range(0, 3))
      0: text.push_back(CH_PLUS);
      1: text.push_back(CH_MINUS);
      default: ;
    endcase
    if (r == AUTO_BASE) begin
      case ($urandom_range(0, 2))
        0: begin
          text.push_back(CH_ZERO);
          text.push_back($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
          eb = HEX_BASE;
        end
        1: begin
          text.push_back(CH_ZERO);
          eb = OCT_BASE;
        end
        default: eb = DEC_BASE;
      endcase
    end else begin
      eb = base_invalid(r) ? DEC_BASE : r;
      if (r == HEX_BASE && $urandom_range(0, 1) == 0) begin
        text.push_back(CH_ZERO);
        text.push_back($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
      end
    end
    // digits needed to pass the signed limit in this base
    full = 0;
    span = MAG_CEILING + 64'd1;
    while (span > 0) begin
      span = span / eb;
      full++;
    end
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, full + 2) : $urandom_range(0, 6);
    repeat (n) text.push_back(digit_char($urandom_range(0, eb - 1)));
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(0, 255)));
    if (text.size() == 0) text.push_back(8'($urandom_range(0, 255)));
  endfunction

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Radix left at its reset value of 10
  task automatic test_decimal();
    byte unsigned text[$];
    send_text("  -123");
    send_text("+2147483647");
    send_text("-2147483648");
    send_text("2147483648");        // one past the positive limit
    send_text("-2147483649");       // one past the negative limit
    send_text("99999999999999");    // keeps consuming after saturation
    send_text("12a9");              // stops on the letter
    send_text("\011\012\013\014\015 42");
    send_text("abc");               // no digit at all
    send_text("-");
    send_text(" 7 x");              // characters after the stop are ignored
    send_text("4\377");
    send_text("\377");
    text = {CH_NUL};
    send_bytes(text);
    text = {CH_ONE, CH_NUL, CH_ONE};
    send_bytes(text);
  endtask

  // 0x prefixes under radix 16 and the auto-detect rules under radix 0
  task automatic test_prefixes();
    set_radix(s2i_pkg::RADIX_W'(HEX_BASE));
    send_text("0x1F");
    send_text("0XfF");
    send_text("0");                 // pending zero counts as a digit
    send_text("0x");
    send_text("-0x7fffffff");
    send_text("0g");
    send_text("0x80000000");
    send_text("ff");
    set_radix(s2i_pkg::RADIX_W'(AUTO_BASE));
    send_text("0");                 // selects octal, consumes nothing
    send_text("017");
    send_text("09");
    send_text("08");
    send_text("0x1a");
    send_text("0X");
    send_text(" -0x10");
    send_text("123");
  endtask

  // Smallest and largest valid bases, then invalid ones
  task automatic test_radix_limits();
    set_radix(s2i_pkg::RADIX_W'(MIN_BASE));
    send_text("1011");
    send_text("-102");
    send_text("1111111111111111111111111111111111");
    set_radix(s2i_pkg::RADIX_W'(MAX_BASE));
    send_text("zZ");
    send_text("-Zz1");
    set_radix(s2i_pkg::RADIX_W'(MIN_BASE - 1));
    send_text("5");
    set_radix(s2i_pkg::RADIX_W'(MAX_BASE + 1));
    send_text("12");
    set_radix(6'd63);
    send_text("  -9");
  endtask

  // A string longer than the index range: the index saturates, the value too
  task automatic test_long_strings();
    byte unsigned text[$];
    set_radix(s2i_pkg::RADIX_W'(DEC_BASE));
    text.delete();
    text.push_back(CH_ONE);
    repeat (MAX_LEN) text.push_back(CH_ZERO);
    text.push_back(CH_X_LO);
    text.push_back(CH_ONE);
    send_bytes(text);
  endtask

  // Bulk of the run: random strings, radix changed every few strings
  task automatic test_random_strings();
    byte unsigned text[$];
    int unsigned mark;
    int unsigned since_change;
    mark = items_sent;
    since_change = 0;
    while (items_sent < mark + RANDOM_ITEMS) begin
      if (since_change == RADIX_EVERY) begin
        set_radix(pick_radix());
        since_change = 0;
      end
      make_number(text, radix_reg);
      send_bytes(text);
      since_change++;
    end
  endtask

  // Back to back at full rate on both sides
  task automatic test_full_rate_tail();
    byte unsigned text[$];
    int unsigned mark;
    idle_on = 1'b0;
    set_radix(s2i_pkg::RADIX_W'(HEX_BASE));
    mark = items_sent;
    while (items_sent < mark + TAIL_ITEMS) begin
      make_number(text, radix_reg);
      send_bytes(text);
    end
  endtask

  initial begin
    clk      = 1'b0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    radix_reg = s2i_pkg::RADIX_RESET;
    clear_scan();
    idle_on = 1'b1;
    cycle_count = 0;
    items_sent = 0;
    strings_sent = 0;
    results_checked = 0;
    radix_writes = 0;
    mismatches = 0;
    // hold reset low, then release it on a falling edge
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    test_decimal();
    test_prefixes();
    test_radix_limits();
    test_long_strings();
    test_random_strings();
    test_full_rate_tail();
    wait_idle();

    $display("run covered %0d strings in %0d characters over %0d radix writes",
             strings_sent, items_sent, radix_writes);
    $display("%0d results compared, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
